// ----- rtl/core/lfe_pkg.sv -----
package lfe_pkg;

    localparam int MAX_LEDS     = 16;
    localparam int CHANNEL_BITS = 12;
    localparam int NUM_CHANNELS = 3;

    localparam int LED_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W    = $clog2(MAX_LEDS + 1);
    localparam int STRIDE_W = CHANNEL_BITS + 1;

    // Field and register widths of the ports.
    localparam int IDX_W      = 4;
    localparam int OP_W       = 2;
    localparam int STEP_W     = 12;
    localparam int LCNT_W     = 5;
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int TDATA_W    = ((IDX_W + NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0]                chan_t;
    typedef logic signed [STRIDE_W-1:0]             stride_t;
    typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] color_t;
    typedef logic [NUM_CHANNELS-1:0][STRIDE_W-1:0]  stride_vec_t;
    typedef logic [STEP_W-1:0]                      step_t;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_LOAD = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT  = 1'b1;

    typedef struct packed {
        logic             set_wr;
        logic             load_start;
        logic             load_wr;
        logic             tick_start;
        logic             upd_en;
        logic             emit_en;
        logic             last;
        logic [LED_W-1:0] led;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             div_done;
        logic             out_free;
        logic             idx_ok;
        logic [CNT_W-1:0] led_total;
    } dp_status_t;

    // One tick of one channel: snap when within one stride, else step and clamp.
    function automatic chan_t chan_step(chan_t cur, chan_t tgt, stride_t st);
        logic signed [STRIDE_W-1:0] diff;
        logic signed [STRIDE_W:0]   sum;
        chan_t                      adiff;
        chan_t                      ast;
        chan_t                      res;
        diff  = $signed({1'b0, cur}) - $signed({1'b0, tgt});
        adiff = diff[STRIDE_W-1] ? chan_t'(-diff) : chan_t'(diff);
        ast   = st[STRIDE_W-1] ? chan_t'(-st) : chan_t'(st);
        sum   = $signed({2'b00, cur}) + $signed({st[STRIDE_W-1], st});
        if (adiff <= ast)
            res = tgt;
        else if (sum[STRIDE_W])
            res = '0;
        else if (sum[STRIDE_W-1])
            res = '1;
        else
            res = sum[CHANNEL_BITS-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/core/lfe_div.sv -----
module lfe_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lfe_pkg::chan_t dividend,
    input  lfe_pkg::step_t divisor,
    output logic          done,
    output lfe_pkg::chan_t quotient
);
    import lfe_pkg::*;

    localparam int ITER_W = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    step_t             rem_reg;
    chan_t             quo_reg;

    logic [STEP_W:0]   trial;
    logic              fits;
    step_t             rem_next;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[CHANNEL_BITS-1]};
        fits     = (trial >= {1'b0, divisor});
        rem_next = fits ? STEP_W'(trial - {1'b0, divisor}) : trial[STEP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[CHANNEL_BITS-2:0], fits};
            if (iter_reg == ITER_W'(CHANNEL_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/lfe_datapath.sv -----
module lfe_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfe_pkg::ctrl_cmd_t                  cmd,
    output lfe_pkg::dp_status_t                 status,
    input  logic                                cfg_we,
    input  logic [lfe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lfe_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [lfe_pkg::IDX_W-1:0]           in_idx,
    input  lfe_pkg::color_t                     in_color,
    output logic [lfe_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tvalid,
    output logic                                m_tlast,
    output logic                                m_tuser,
    input  logic                                m_tready
);
    import lfe_pkg::*;

    color_t      cur_reg    [MAX_LEDS];
    color_t      tgt_reg    [MAX_LEDS];
    stride_vec_t st_reg     [MAX_LEDS];

    step_t               step_reg;
    logic [LCNT_W-1:0]   lcnt_reg;

    logic [LED_W-1:0]        ld_led_reg;
    color_t                  ld_tgt_reg;
    logic [NUM_CHANNELS-1:0] ld_neg_reg;
    logic [NUM_CHANNELS-1:0] ld_nz_reg;

    logic                all_hit_reg;
    logic                m_tvalid_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    logic [LED_W-1:0]    rd_led;
    color_t              rd_cur;
    color_t              rd_tgt;
    stride_vec_t         rd_st;
    step_t               divisor;
    logic signed [STRIDE_W-1:0] delta [NUM_CHANNELS];
    chan_t               abs_dist [NUM_CHANNELS];
    chan_t               quo      [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] div_done_vec;
    color_t              upd_color_next;
    stride_vec_t         stride_next;
    chan_t               mag;
    logic                upd_hit;
    logic [TDATA_W-1:0]  m_tdata_next;

    // The load reads the addressed LED; update and emit read the walked LED.
    assign rd_led  = cmd.load_start ? LED_W'(in_idx) : cmd.led;
    assign rd_cur  = cur_reg[rd_led];
    assign rd_tgt  = tgt_reg[cmd.led];
    assign rd_st   = st_reg[cmd.led];
    assign divisor = (step_reg == '0) ? STEP_W'(1) : step_reg;

    always_comb
    begin
        upd_hit = 1'b1;
        mag     = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            delta[c]    = $signed({1'b0, in_color[c]}) - $signed({1'b0, rd_cur[c]});
            abs_dist[c] = delta[c][STRIDE_W-1] ? chan_t'(-delta[c]) : chan_t'(delta[c]);

            upd_color_next[c] = chan_step(rd_cur[c], rd_tgt[c], rd_st[c]);
            if (upd_color_next[c] != rd_tgt[c])
                upd_hit = 1'b0;

            // A nonzero distance always moves by at least one code.
            mag = (quo[c] == '0 && ld_nz_reg[c]) ? chan_t'(1) : quo[c];
            stride_next[c] = ld_neg_reg[c] ? -stride_t'({1'b0, mag}) : stride_t'({1'b0, mag});
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_div
        lfe_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (cmd.load_start),
            .dividend (abs_dist[g]),
            .divisor  (divisor),
            .done     (div_done_vec[g]),
            .quotient (quo[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '{default: '0};
            tgt_reg  <= '{default: '0};
            st_reg   <= '{default: '0};
            step_reg <= STEP_W'(1);
            lcnt_reg <= LCNT_W'(MAX_LEDS);
        end
        else
        begin
            if (cfg_we && cfg_addr == REG_STEP_COUNT)
                step_reg <= cfg_wdata[STEP_W-1:0];
            if (cfg_we && cfg_addr == REG_LED_COUNT)
                lcnt_reg <= cfg_wdata[LCNT_W-1:0];

            if (cmd.set_wr)
                cur_reg[LED_W'(in_idx)] <= in_color;
            else if (cmd.upd_en)
                cur_reg[cmd.led] <= upd_color_next;

            if (cmd.load_wr)
            begin
                tgt_reg[ld_led_reg] <= ld_tgt_reg;
                st_reg[ld_led_reg]  <= stride_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            ld_led_reg <= LED_W'(in_idx);
            ld_tgt_reg <= in_color;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                ld_neg_reg[c] <= delta[c][STRIDE_W-1];
                ld_nz_reg[c]  <= (delta[c] != '0);
            end
        end
    end

    // The all-at-target flag is gathered over the update pass and then
    // repeated on every result of the emit pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            all_hit_reg <= 1'b1;
        else if (cmd.tick_start)
            all_hit_reg <= 1'b1;
        else if (cmd.upd_en)
            all_hit_reg <= all_hit_reg & upd_hit;
    end

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[IDX_W-1:0] = IDX_W'(cmd.led);
        for (int c = 0; c < NUM_CHANNELS; c++)
            m_tdata_next[IDX_W + c*CHANNEL_BITS +: CHANNEL_BITS] = rd_cur[c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit_en)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= cmd.last;
            m_tuser_reg <= all_hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    assign status.div_done  = &div_done_vec;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.idx_ok    = (int'(in_idx) < MAX_LEDS);
    assign status.led_total = (int'(lcnt_reg) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : CNT_W'(lcnt_reg);

endmodule

// ----- rtl/core/lfe_ctrl.sv -----
module lfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lfe_pkg::op_t         op,
    input  lfe_pkg::dp_status_t  status,
    output lfe_pkg::ctrl_cmd_t   cmd
);
    import lfe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [LED_W-1:0] led_reg;
    logic [LED_W-1:0] led_next;
    logic             rdy_reg;
    logic             accept;
    logic             at_last;

    assign accept  = s_tvalid && rdy_reg;
    assign at_last = (CNT_W'(led_reg) + CNT_W'(1) == status.led_total);

    always_comb
    begin
        cmd        = '0;
        cmd.led    = led_reg;
        cmd.last   = at_last;
        state_next = state_reg;
        led_next   = led_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_SET:
                        begin
                            cmd.set_wr = status.idx_ok;
                        end
                        OP_LOAD:
                        begin
                            cmd.load_start = status.idx_ok;
                            if (status.idx_ok)
                                state_next = ST_DIV;
                        end
                        OP_TICK:
                        begin
                            if (status.led_total != '0)
                            begin
                                cmd.tick_start = 1'b1;
                                led_next       = '0;
                                state_next     = ST_UPDATE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                cmd.upd_en = 1'b1;
                if (at_last)
                begin
                    led_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    led_next = led_reg + LED_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    if (at_last)
                        state_next = ST_IDLE;
                    else
                        led_next = led_reg + LED_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            led_reg   <= '0;
            rdy_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            led_reg   <= led_next;
            rdy_reg   <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = rdy_reg;

endmodule

// ----- rtl/core/led_linear_fade_engine.sv -----
// Channel   Direction  Width  Contents
// s_*       in         40+2   tdata: led_index, red, green, blue; tuser: operation
// m_*       out        40+2   tdata: led_number, red_out, green_out, blue_out;
//                             tlast: last; tuser: all_done
// cfg_*     in         1+12   cfg_addr 0 step_count, 1 led_count; no read-back
//
// A load runs through the bit-serial dividers that form the strides, one
// quotient bit per cycle. A tick walks the LEDs one per cycle through the
// single update path, then one per cycle through the output register.
// Output stalls hold the emit pass; no input is taken until the last result
// is in the output register. Reset clears all colors, targets and strides
// at once and sets step_count to 1 and led_count to 16.
module led_linear_fade_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfe_pkg::TDATA_W-1:0]       s_tdata,   // led_index, red, green, blue
    input  logic [lfe_pkg::OP_W-1:0]          s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lfe_pkg::TDATA_W-1:0]       m_tdata,   // led_number, red_out, green_out, blue_out
    output logic                              m_tlast,
    output logic                              m_tuser,   // all_done
    input  logic                              cfg_we,
    input  logic [lfe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lfe_pkg::CFG_W-1:0]         cfg_wdata
);
    import lfe_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [IDX_W-1:0]  in_idx;
    color_t            in_color;

    always_comb
    begin
        in_idx = s_tdata[IDX_W-1:0];
        for (int c = 0; c < NUM_CHANNELS; c++)
            in_color[c] = s_tdata[IDX_W + c*CHANNEL_BITS +: CHANNEL_BITS];
    end

    lfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op_t'(s_tuser)),
        .status   (status),
        .cmd      (cmd)
    );

    lfe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_idx    (in_idx),
        .in_color  (in_color),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tready  (m_tready)
    );

endmodule

// ----- rtl/core/lfe_checker.sv -----
module lfe_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lfe_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic                        m_tuser
);
    import lfe_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // No input is ready while a result that is not the last of its tick is on the output.
    a_no_input_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a tick");

    // Results of one tick follow back to back in LED order with one flag.
    a_led_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[IDX_W-1:0] == $past(m_tdata[IDX_W-1:0]) + 1'b1
            && m_tuser == $past(m_tuser))
        else $error("tick results out of order");

    // An accepted input transaction never brings up a result in the very next cycle.
    a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised right after an input transaction");

endmodule

bind led_linear_fade_engine lfe_checker u_lfe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- tb/lfe_fade_checker.sv -----
module lfe_fade_checker
    import lfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // led_index, red, green, blue
    input  logic [OP_W-1:0]       s_tuser,   // operation
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,   // led_number, red_out, green_out, blue_out
    input  logic                  m_tlast,
    input  logic                  m_tuser,   // all_done
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_MAX  = (1 << CHANNEL_BITS) - 1;
    localparam int COLOR_W   = NUM_CHANNELS * CHANNEL_BITS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [LED_W-1:0] led;
        color_t           color;
        logic             last;
        logic             all_done;
    } fade_result_t;

    color_t              cur_color[MAX_LEDS];
    color_t              target_color[MAX_LEDS];
    stride_t             strides[MAX_LEDS][NUM_CHANNELS];
    logic [STEP_W-1:0]   step_cnt;
    logic [LCNT_W-1:0]   led_total;
    fade_result_t        colors_due[$];

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // A load fixes the target and the per-channel stride; a nonzero distance never
    // gets a zero stride.
    task automatic load_target(input logic [LED_W-1:0] led, input color_t value);
        int divisor;
        int delta;
        int mag;
        divisor = (step_cnt == '0) ? 1 : int'(step_cnt);
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            delta = int'(value[c]) - int'(cur_color[led][c]);
            mag   = magnitude(delta) / divisor;
            if (mag == 0 && delta != 0)
                mag = 1;
            target_color[led][c] = value[c];
            strides[led][c]      = stride_t'((delta < 0) ? -mag : mag);
        end
    endtask

    task automatic advance_fades();
        int           active;
        int           now;
        int           goal;
        int           st;
        logic         all_there;
        fade_result_t res;
        active    = (led_total > MAX_LEDS) ? MAX_LEDS : int'(led_total);
        all_there = 1'b1;
        for (int k = 0; k < active; k++)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                now  = int'(cur_color[k][c]);
                goal = int'(target_color[k][c]);
                st   = int'(strides[k][c]);
                if (magnitude(now - goal) <= magnitude(st))
                    now = goal;
                else
                begin
                    now = now + st;
                    if (now < 0)
                        now = 0;
                    if (now > CHAN_MAX)
                        now = CHAN_MAX;
                end
                cur_color[k][c] = chan_t'(now);
                if (now != goal)
                    all_there = 1'b0;
            end
        end
        for (int k = 0; k < active; k++)
        begin
            res.led      = LED_W'(k);
            res.color    = cur_color[k];
            res.last     = (k + 1 == active);
            res.all_done = all_there;
            colors_due   = {colors_due, res};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fade_result_t     want;
        logic [LED_W-1:0] got_led;
        color_t           got_color;
        logic             bad;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LEDS; k++)
            begin
                cur_color[k]    = '0;
                target_color[k] = '0;
                for (int c = 0; c < NUM_CHANNELS; c++)
                    strides[k][c] = '0;
            end
            step_cnt  = STEP_W'(1);
            led_total = LCNT_W'(MAX_LEDS);
            colors_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_STEP_COUNT: step_cnt  = cfg_wdata[STEP_W-1:0];
                    REG_LED_COUNT:  led_total = cfg_wdata[LCNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got_led   = m_tdata[LED_W-1:0];
                got_color = color_t'(m_tdata[IDX_W +: COLOR_W]);
                results_checked++;
                if (colors_due.size() == 0)
                    flag_error($sformatf("unexpected result: led %0d rgb %h/%h/%h last %b done %b",
                        got_led, got_color[0], got_color[1], got_color[2], m_tlast, m_tuser));
                else
                begin
                    want = colors_due.pop_front();
                    bad  = (got_led !== want.led) || (m_tlast !== want.last)
                        || (m_tuser !== want.all_done);
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        if (got_color[c] !== want.color[c])
                            bad = 1'b1;
                    if (bad)
                        flag_error($sformatf(
                            "result mismatch: expected led %0d rgb %h/%h/%h last %b done %b, got led %0d rgb %h/%h/%h last %b done %b",
                            want.led, want.color[0], want.color[1], want.color[2], want.last,
                            want.all_done, got_led, got_color[0], got_color[1], got_color[2],
                            m_tlast, m_tuser));
                end
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    OP_SET:  cur_color[s_tdata[LED_W-1:0]] = color_t'(s_tdata[IDX_W +: COLOR_W]);
                    OP_LOAD: load_target(s_tdata[LED_W-1:0], color_t'(s_tdata[IDX_W +: COLOR_W]));
                    OP_TICK: advance_fades();
                    default: ;
                endcase
            end
            pending <= colors_due.size();
        end
    end

endmodule

// ----- tb/led_linear_fade_engine_test.sv -----
module led_linear_fade_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lfe_pkg::*;

    localparam int CHAN_MAX       = (1 << CHANNEL_BITS) - 1;
    localparam int RANDOM_ITEMS   = 80;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKE
    } sink_mode_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // led_index, red, green, blue
    logic [OP_W-1:0]       s_tuser   = '0;   // operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // led_number, red_out, green_out, blue_out
    logic                  m_tlast;
    logic                  m_tuser;          // all_done
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int mismatches;
    int pending;
    int results_checked;
    int n_set;
    int n_load;
    int n_tick;
    int n_ignored;
    int n_settings;
    int burst_left;
    int directed_items;

    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_left = 0;

    led_linear_fade_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lfe_fade_checker fade_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver switches between always ready, coin-flip ready and mostly stalled.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
            sink_left <= $urandom_range(16, 96);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_OPEN:  m_tready <= 1'b1;
            SINK_COIN:  m_tready <= $urandom_range(0, 1);
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("led_linear_fade_engine regression: fail");
        $finish;
    end

    function automatic chan_t rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return chan_t'($urandom_range(0, CHAN_MAX));
        endcase
    endfunction

    // Bursts keep tvalid high across transactions; between bursts tvalid always drops.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] led,
                             input chan_t r, input chan_t g, input chan_t b);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, g, r, led};
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_SET:  n_set++;
            OP_LOAD: n_load++;
            OP_TICK: n_tick++;
            default: n_ignored++;
        endcase
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 9);
        end
    endtask

    // Loads produce no results, so the block may still be dividing after the queue empties.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_config(input logic [STEP_W-1:0] step_val,
                                input logic [LCNT_W-1:0] count_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_STEP_COUNT;
        cfg_wdata <= CFG_W'(step_val);
        @(posedge clk);
        cfg_addr  <= REG_LED_COUNT;
        cfg_wdata <= CFG_W'(count_val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // One fade: register settings, colors and targets for a few LEDs, a run of ticks, then some noise.
    task automatic fade_scene();
        logic [STEP_W-1:0] step_val;
        logic [LCNT_W-1:0] count_val;
        logic [IDX_W-1:0]  led;
        int                active;
        case ($urandom_range(0, 7))
            0:       step_val = STEP_W'(1);
            1:       step_val = STEP_W'(2);
            2, 3:    step_val = STEP_W'($urandom_range(3, 6));
            4:       step_val = STEP_W'($urandom_range(7, 40));
            5:       step_val = '1;
            6:       step_val = '0;
            default: step_val = STEP_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 7))
            0:       count_val = LCNT_W'(MAX_LEDS);
            1:       count_val = '0;
            2:       count_val = LCNT_W'($urandom_range(MAX_LEDS + 1, 31));
            default: count_val = LCNT_W'($urandom_range(1, MAX_LEDS));
        endcase
        write_config(step_val, count_val);
        active = (count_val > MAX_LEDS) ? MAX_LEDS : int'(count_val);

        repeat ($urandom_range(1, 4))
        begin
            if (active > 0 && $urandom_range(0, 4) != 0)
                led = IDX_W'($urandom_range(0, active - 1));
            else
                led = IDX_W'($urandom);
            if ($urandom_range(0, 4) != 0)
                send_item(OP_SET, led, rand_chan(), rand_chan(), rand_chan());
            send_item(OP_LOAD, led, rand_chan(), rand_chan(), rand_chan());
        end
        repeat ($urandom_range(2, 7))
            send_item(OP_TICK, IDX_W'($urandom), rand_chan(), rand_chan(), rand_chan());
        repeat ($urandom_range(0, 3))
            send_item(OP_W'($urandom), IDX_W'($urandom), rand_chan(), rand_chan(), rand_chan());
        wait_idle();
    endtask

    initial
    begin
        n_set      = 0;
        n_load     = 0;
        n_tick     = 0;
        n_ignored  = 0;
        n_settings = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(STEP_W'(4), LCNT_W'(MAX_LEDS));
        send_item(OP_SET, 4'd0, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(OP_SET, 4'd15, 12'hAAA, 12'h555, 12'hFFF);
        send_item(OP_LOAD, 4'd0, 12'h000, 12'h000, 12'h000);
        send_item(OP_LOAD, 4'd15, 12'h000, 12'hFFF, 12'hAAA);
        // Overshooting the target with a set leaves the stride pointing away.
        send_item(OP_LOAD, 4'd1, 12'd2000, 12'd0, 12'hFFF);
        send_item(OP_SET, 4'd1, 12'd3000, 12'd0, 12'd0);
        send_item(OP_SET, 4'd4, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(OP_LOAD, 4'd4, 12'd2000, 12'd2000, 12'd2000);
        send_item(OP_SET, 4'd4, 12'd500, 12'd3000, 12'd2100);
        // Zero stride with the color moved off target afterwards: the channel stays put.
        send_item(OP_LOAD, 4'd2, 12'd0, 12'd0, 12'd0);
        send_item(OP_SET, 4'd2, 12'd50, 12'd0, 12'hFFF);
        send_item(OP_UNUSED, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF);
        repeat (4)
            send_item(OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        write_config('0, '0);
        send_item(OP_TICK, 4'd3, 12'd1, 12'd2, 12'd3);
        send_item(OP_LOAD, 4'd5, 12'd3, 12'd0, 12'hFFF);
        send_item(OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        write_config('1, '1);
        send_item(OP_LOAD, 4'd7, 12'd10, 12'hFFF, 12'd1);
        repeat (2)
            send_item(OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        write_config(STEP_W'(2), LCNT_W'(1));
        repeat (2)
            send_item(OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        directed_items = n_set + n_load + n_tick;
        while (n_set + n_load + n_tick - directed_items < RANDOM_ITEMS)
            fade_scene();

        $display("Covered %0d sets, %0d loads, %0d ticks and %0d ignored transactions under %0d register settings.",
                 n_set, n_load, n_tick, n_ignored, n_settings);
        $display("Checked %0d output transactions against predicted colors; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("led_linear_fade_engine regression: pass");
        else
            $display("led_linear_fade_engine regression: fail");
        $finish;
    end

endmodule

// ----- led_linear_fade_engine.f -----
rtl/core/lfe_pkg.sv
rtl/core/lfe_div.sv
rtl/core/lfe_datapath.sv
rtl/core/lfe_ctrl.sv
rtl/core/led_linear_fade_engine.sv
rtl/core/lfe_checker.sv
tb/lfe_fade_checker.sv
tb/led_linear_fade_engine_test.sv
